### rtl/core/sha_strm_pkg.sv
// shared types, constants and round functions of the sha-256 stream hasher
package sha_strm_pkg;

  localparam int unsigned FILL_W  = 6;
  localparam int unsigned BYTES_W = 61;
  localparam int unsigned ROUND_W = 6;
  localparam int unsigned WIDX_W  = 3;

  localparam logic [FILL_W-1:0]  FILL_LAST  = 6'd63;
  localparam logic [FILL_W-1:0]  LEN_START  = 6'd56;
  localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
  localparam logic [WIDX_W-1:0]  WORD_LAST  = 3'd7;
  localparam logic [7:0]         PAD_MARK_BYTE = 8'h80;

  // input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic [31:0]       digest_word;
    logic [WIDX_W-1:0] word_index;
    logic              final_word;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PAD_MARK,
    PAD_ZERO,
    PAD_LEN
  } pad_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic               absorb;
    logic               pad_shift;
    pad_sel_t           pad_sel;
    logic               load_work;
    logic               round;
    logic [ROUND_W-1:0] round_idx;
    logic               add;
    logic               emit;
    logic [WIDX_W-1:0]  emit_idx;
    logic               reinit;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              out_free;
  } dp_stat_t;

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### rtl/core/sha_strm_ctrl.sv
// controller state machine: byte intake, padding sequence, rounds and digest emission
module sha_strm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  sha_strm_pkg::in_beat_t in_data,
  output logic                  in_ready,
  input  sha_strm_pkg::dp_stat_t stat,
  output sha_strm_pkg::ctrl_cmd_t cmd
);

  sha_strm_pkg::state_t   state;
  sha_strm_pkg::state_t   state_next;
  sha_strm_pkg::pad_sel_t pad_sel_c;

  logic                                pad_mode;
  logic                                sent_mark;
  logic                                len_ok;
  logic                                final_blk;
  logic [sha_strm_pkg::ROUND_W-1:0]    round_cnt;
  logic [sha_strm_pkg::WIDX_W-1:0]     word_cnt;
  logic                                accept;
  logic                                fill_end;

  assign accept   = in_valid && (state == sha_strm_pkg::ST_IDLE);
  assign fill_end = (stat.fill == sha_strm_pkg::FILL_LAST);

  // which padding byte goes in next
  always_comb begin
    if (!sent_mark) begin
      pad_sel_c = sha_strm_pkg::PAD_MARK;
    end else if (len_ok && (stat.fill >= sha_strm_pkg::LEN_START)) begin
      pad_sel_c = sha_strm_pkg::PAD_LEN;
    end else begin
      pad_sel_c = sha_strm_pkg::PAD_ZERO;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sha_strm_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.byte_present && fill_end) begin
            state_next = sha_strm_pkg::ST_LOAD;
          end else if (in_data.last) begin
            state_next = sha_strm_pkg::ST_PAD;
          end
        end
      end
      sha_strm_pkg::ST_PAD: begin
        if (fill_end) begin
          state_next = sha_strm_pkg::ST_LOAD;
        end
      end
      sha_strm_pkg::ST_LOAD: begin
        state_next = sha_strm_pkg::ST_ROUND;
      end
      sha_strm_pkg::ST_ROUND: begin
        if (round_cnt == sha_strm_pkg::ROUND_LAST) begin
          state_next = sha_strm_pkg::ST_ADD;
        end
      end
      sha_strm_pkg::ST_ADD: begin
        if (final_blk) begin
          state_next = sha_strm_pkg::ST_EMIT;
        end else if (pad_mode) begin
          state_next = sha_strm_pkg::ST_PAD;
        end else begin
          state_next = sha_strm_pkg::ST_IDLE;
        end
      end
      sha_strm_pkg::ST_EMIT: begin
        if (stat.out_free && (word_cnt == sha_strm_pkg::WORD_LAST)) begin
          state_next = sha_strm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sha_strm_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    in_ready = (state == sha_strm_pkg::ST_IDLE);
    cmd = '0;
    cmd.pad_sel = pad_sel_c;
    cmd.round_idx = round_cnt;
    cmd.emit_idx = word_cnt;
    case (state)
      sha_strm_pkg::ST_IDLE: begin
        cmd.absorb = accept && in_data.byte_present;
      end
      sha_strm_pkg::ST_PAD: begin
        cmd.pad_shift = 1'b1;
      end
      sha_strm_pkg::ST_LOAD: begin
        cmd.load_work = 1'b1;
      end
      sha_strm_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
      end
      sha_strm_pkg::ST_ADD: begin
        cmd.add = 1'b1;
      end
      sha_strm_pkg::ST_EMIT: begin
        cmd.emit = stat.out_free;
        cmd.reinit = stat.out_free && (word_cnt == sha_strm_pkg::WORD_LAST);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // state and padding flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha_strm_pkg::ST_IDLE;
      pad_mode  <= 1'b0;
      sent_mark <= 1'b0;
      len_ok    <= 1'b0;
      final_blk <= 1'b0;
      round_cnt <= '0;
      word_cnt  <= '0;
    end else begin
      state <= state_next;
      case (state)
        sha_strm_pkg::ST_IDLE: begin
          if (accept) begin
            pad_mode  <= in_data.last;
            sent_mark <= 1'b0;
            len_ok    <= 1'b0;
            final_blk <= 1'b0;
          end
        end
        sha_strm_pkg::ST_PAD: begin
          // the length fits in this block only if the marker lands below the length field
          if (!sent_mark) begin
            sent_mark <= 1'b1;
            len_ok    <= (stat.fill < sha_strm_pkg::LEN_START);
          end
          if (fill_end && (pad_sel_c == sha_strm_pkg::PAD_LEN)) begin
            final_blk <= 1'b1;
          end
        end
        sha_strm_pkg::ST_LOAD: begin
          round_cnt <= '0;
        end
        sha_strm_pkg::ST_ROUND: begin
          round_cnt <= round_cnt + 1'b1;
        end
        sha_strm_pkg::ST_ADD: begin
          // marker spilled into the previous block: the new block takes the length
          if (sent_mark) begin
            len_ok <= 1'b1;
          end
        end
        sha_strm_pkg::ST_EMIT: begin
          if (stat.out_free) begin
            word_cnt <= word_cnt + 1'b1;
            if (word_cnt == sha_strm_pkg::WORD_LAST) begin
              pad_mode <= 1'b0;
            end
          end
        end
        default: begin
          pad_mode <= 1'b0;
        end
      endcase
    end
  end

endmodule

### rtl/core/sha_strm_dp.sv
// datapath: schedule window, working variables, chaining words, length and output register
module sha_strm_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  sha_strm_pkg::in_beat_t  in_data,
  input  sha_strm_pkg::ctrl_cmd_t cmd,
  output sha_strm_pkg::dp_stat_t  stat,
  output logic                    out_valid,
  input  logic                    out_ready,
  output sha_strm_pkg::out_beat_t out_data
);

  // window holds w[t..t+15], oldest word at the top
  logic [511:0]                      win;
  logic [7:0][31:0]                  hash;
  logic [31:0]                       wa, wb, wc, wd, we, wf, wg, wh;
  logic [sha_strm_pkg::FILL_W-1:0]   fill;
  logic [sha_strm_pkg::BYTES_W-1:0]  msg_bytes;

  logic [63:0] bit_len;
  logic [7:0]  pad_byte;
  logic [2:0]  len_pos;
  logic [31:0] w_t, w_new, t1, t2;

  assign bit_len = {msg_bytes, 3'b000};
  assign len_pos = fill[2:0];

  // padding byte select; length goes out most significant byte first
  always_comb begin
    case (cmd.pad_sel)
      sha_strm_pkg::PAD_MARK: pad_byte = sha_strm_pkg::PAD_MARK_BYTE;
      sha_strm_pkg::PAD_LEN:  pad_byte = bit_len[8 * (7 - len_pos) +: 8];
      default:                pad_byte = 8'h00;
    endcase
  end

  // message schedule and round function
  assign w_t   = win[511:480];
  assign w_new = w_t + sha_strm_pkg::small_sigma0(win[479:448]) + win[223:192]
               + sha_strm_pkg::small_sigma1(win[63:32]);
  assign t1 = wh + sha_strm_pkg::big_sigma1(we) + ((we & wf) ^ (~we & wg))
            + sha_strm_pkg::ROUND_K[cmd.round_idx] + w_t;
  assign t2 = sha_strm_pkg::big_sigma0(wa) + ((wa & wb) ^ (wa & wc) ^ (wb & wc));

  assign stat.fill     = fill;
  assign stat.out_free = !out_valid || out_ready;

  // schedule window
  always_ff @(posedge clk) begin
    if (cmd.absorb) begin
      win <= {win[503:0], in_data.data_byte};
    end else if (cmd.pad_shift) begin
      win <= {win[503:0], pad_byte};
    end else if (cmd.round) begin
      win <= {win[479:0], w_new};
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      {wa, wb, wc, wd, we, wf, wg, wh} <= {hash[0], hash[1], hash[2], hash[3],
                                           hash[4], hash[5], hash[6], hash[7]};
    end else if (cmd.round) begin
      wh <= wg;
      wg <= wf;
      wf <= we;
      we <= wd + t1;
      wd <= wc;
      wc <= wb;
      wb <= wa;
      wa <= t1 + t2;
    end
  end

  // chaining words, fill count and message length
  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= sha_strm_pkg::HASH_INIT[i];
      end
      fill      <= '0;
      msg_bytes <= '0;
    end else begin
      if (cmd.add) begin
        hash[0] <= hash[0] + wa;
        hash[1] <= hash[1] + wb;
        hash[2] <= hash[2] + wc;
        hash[3] <= hash[3] + wd;
        hash[4] <= hash[4] + we;
        hash[5] <= hash[5] + wf;
        hash[6] <= hash[6] + wg;
        hash[7] <= hash[7] + wh;
      end
      if (cmd.load_work) begin
        fill <= '0;
      end else if (cmd.absorb || cmd.pad_shift) begin
        fill <= fill + 1'b1;
      end
      if (cmd.absorb) begin
        msg_bytes <= msg_bytes + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.digest_word <= hash[cmd.emit_idx];
      out_data.word_index  <= cmd.emit_idx;
      out_data.final_word  <= (cmd.emit_idx == sha_strm_pkg::WORD_LAST);
    end
  end

endmodule

### rtl/core/sha256_stream_hasher_top.sv
// top level of the sha-256 stream hasher
// throughput: one byte beat per cycle while buffering; each full 64-byte block then holds
//   intake for its load, the 64 rounds in the single round unit and the chain add
// completion: after a last beat with f bytes buffered the block is padded and compressed;
//   f >= 56 adds a second padded block; then 8 digest beats, one per cycle when not stalled
// reset: synchronous; chaining words to the initial values, counts cleared, output empty
module sha256_stream_hasher_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  sha_strm_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output sha_strm_pkg::out_beat_t out_data
);

  sha_strm_pkg::ctrl_cmd_t cmd;
  sha_strm_pkg::dp_stat_t  stat;

  sha_strm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sha_strm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/core/sha_strm_chk.sv
// port-level checker for the sha-256 stream hasher, bound to the top level
module sha_strm_chk (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input sha_strm_pkg::out_beat_t out_data
);

  // a stalled output beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // final flag marks exactly the last digest word
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.final_word == (out_data.word_index == sha_strm_pkg::WORD_LAST)))
    else $error("final_word does not match word_index");

  // digest words follow one another in order
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid ||
      (out_data.word_index == $past(out_data.word_index) + 3'd1))
    else $error("digest word out of order");

  // no new input while a digest is still being delivered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.final_word |-> !in_ready)
    else $error("input taken during digest output");

endmodule

bind sha256_stream_hasher_top sha_strm_chk u_chk (.*);

### bench/sha256_stream_hasher_top_tb.sv
// self-checking testbench for the sha-256 stream hasher top level
`timescale 1ns / 100ps

module sha256_stream_hasher_top_tb;

  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned ITEM_TARGET      = 330;
  localparam int unsigned IDLE_PCT         = 35;
  localparam int unsigned SINK_HOLD_CYCLES = 1500;
  localparam int unsigned TAIL_CYCLES      = 400;
  localparam logic [7:0]  PAD_LEAD         = 8'h80;

  // fips 180-4 round constants, index 0 first
  localparam logic [0:63][31:0] K_TAB = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // initial chaining words h0..h7
  localparam logic [0:7][31:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // digest predictor and store of pending digest beats
  class sha256_digest_board;
    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    int unsigned fill;
    logic [60:0] msg_len;
    sha_strm_pkg::out_beat_t digests [$];
    int unsigned errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = H_INIT[i];
      fill = 0;
      msg_len = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of the block buffer into the chain
    function void absorb_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++)
        w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) +
               w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int i = 0; i < 64; i++) begin
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + K_TAB[i] + w[i];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    // pad, run the final compressions and queue the eight digest words
    function void finish_message();
      logic [63:0] bit_len;
      int unsigned pos;
      sha_strm_pkg::out_beat_t beat;
      bit_len = {msg_len, 3'b000};
      pos = fill;
      blk[pos] = PAD_LEAD;
      pos++;
      // length field no longer fits, spill into a second block
      if (pos > 56) begin
        for (int i = pos; i < 64; i++) blk[i] = '0;
        absorb_block();
        pos = 0;
      end
      for (int i = pos; i < 56; i++) blk[i] = '0;
      for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
      absorb_block();
      for (int i = 0; i < 8; i++) begin
        beat.digest_word = chain[i];
        beat.word_index  = 3'(i);
        beat.final_word  = (i == 7);
        digests.push_back(beat);
      end
      restart();
    endfunction

    // accepted input beat
    function void note_beat(sha_strm_pkg::in_beat_t beat);
      if (beat.byte_present) begin
        blk[fill] = beat.data_byte;
        fill++;
        msg_len++;
        if (fill == 64) begin
          absorb_block();
          fill = 0;
        end
      end
      if (beat.last) finish_message();
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    // accepted output beat against the oldest pending digest word
    task check_beat(sha_strm_pkg::out_beat_t got);
      sha_strm_pkg::out_beat_t want;
      if (digests.size() == 0) begin
        report($sformatf("digest beat %h with nothing pending", got));
        return;
      end
      want = digests.pop_front();
      compare_field("digest_word", got.digest_word, want.digest_word);
      compare_field("word_index", 32'(got.word_index), 32'(want.word_index));
      compare_field("final_word", 32'(got.final_word), 32'(want.final_word));
    endtask

    function int unsigned pending();
      return digests.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  sha_strm_pkg::in_beat_t  in_data;
  logic                    out_valid;
  logic                    out_ready;
  sha_strm_pkg::out_beat_t out_data;

  sha256_digest_board board;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_req;
  int unsigned sent_items;
  int unsigned cycle_count;

  sha256_stream_hasher_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // digest side: random backpressure plus requested long hold-offs
  initial begin : sink_side
    int unsigned seen;
    seen = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != seen) begin
        seen = hold_req;
        out_ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // check every accepted digest beat
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_beat(out_data);
  end

  function automatic sha_strm_pkg::in_beat_t beat_of(logic [7:0] data, logic present,
                                                     logic fin);
    sha_strm_pkg::in_beat_t beat;
    beat.data_byte    = data;
    beat.byte_present = present;
    beat.last         = fin;
    return beat;
  endfunction

  // offer one beat, starting and ending at a falling edge
  task automatic send_beat(input sha_strm_pkg::in_beat_t beat);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_beat(beat);
    if (beat.byte_present || beat.last) sent_items++;
    @(negedge clk);
  endtask

  // one message of random bytes, ended on the last byte or by a bare last beat
  task automatic send_message(input int unsigned nbytes);
    bit split_tail;
    split_tail = (nbytes == 0) || ($urandom_range(1) == 1);
    for (int unsigned i = 0; i < nbytes; i++) begin
      // occasional empty beat in the middle of the stream
      if ($urandom_range(9) == 0) send_beat(beat_of(8'($urandom_range(255)), 1'b0, 1'b0));
      send_beat(beat_of(8'($urandom_range(255)), 1'b1, (i == nbytes - 1) && !split_tail));
    end
    if (split_tail) send_beat(beat_of(8'($urandom_range(255)), 1'b0, 1'b1));
  endtask

  task automatic wait_for_digests();
    in_valid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
  endtask

  // stimulus
  initial begin : stimulus
    int unsigned pick;
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    hold_req = 0;
    sent_items = 0;
    src_idle_pct = IDLE_PCT;
    sink_idle_pct = IDLE_PCT;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: idle beat, empty message, extreme bytes, bare and combined last
    send_beat(beat_of(8'h5a, 1'b0, 1'b0));
    send_beat(beat_of(8'hff, 1'b0, 1'b1));
    send_beat(beat_of(8'h00, 1'b1, 1'b1));
    send_beat(beat_of(8'hff, 1'b1, 1'b0));
    send_beat(beat_of(8'h00, 1'b0, 1'b1));
    send_beat(beat_of(8'h61, 1'b1, 1'b0));
    send_beat(beat_of(8'h62, 1'b1, 1'b0));
    send_beat(beat_of(8'ha5, 1'b0, 1'b0));
    send_beat(beat_of(8'h63, 1'b1, 1'b1));
    send_beat(beat_of(8'h80, 1'b1, 1'b0));
    send_beat(beat_of(8'h7f, 1'b1, 1'b0));
    send_beat(beat_of(8'h01, 1'b1, 1'b0));
    send_beat(beat_of(8'hfe, 1'b1, 1'b1));
    send_beat(beat_of(8'h00, 1'b0, 1'b0));
    send_beat(beat_of(8'hff, 1'b0, 1'b1));

    // digest side holds off while short messages keep coming
    hold_req <= hold_req + 1;
    for (int i = 0; i < 6; i++) send_message($urandom_range(0, 4));
    wait_for_digests();

    // lengths around the padding boundary and the full block, no idling at all
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    send_message(55);
    send_message(56);
    send_message(64);
    src_idle_pct = IDLE_PCT;
    sink_idle_pct <= IDLE_PCT;

    // random messages, mostly short with some near a block boundary
    while (sent_items < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 65) send_message($urandom_range(0, 8));
      else if (pick < 90) send_message($urandom_range(9, 40));
      else send_message($urandom_range(57, 66));
    end

    wait_for_digests();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (board.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
rtl/core/sha_strm_pkg.sv
rtl/core/sha_strm_ctrl.sv
rtl/core/sha_strm_dp.sv
rtl/core/sha256_stream_hasher_top.sv
rtl/core/sha_strm_chk.sv
bench/sha256_stream_hasher_top_tb.sv
